[rtl/irts_pkg.sv]
package irts_pkg;

  // Sequence mode codes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Request function codes
  localparam logic [1:0] FUNC_START_READ  = 2'd0;
  localparam logic [1:0] FUNC_START_WRITE = 2'd1;
  localparam logic [1:0] FUNC_BUS_EVENT   = 2'd2;

  // Bus action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_TX     = 3'd2;
  localparam logic [2:0] ACT_RSTART = 3'd3;
  localparam logic [2:0] ACT_RECV   = 3'd4;
  localparam logic [2:0] ACT_ACK    = 3'd5;
  localparam logic [2:0] ACT_NACK   = 3'd6;
  localparam logic [2:0] ACT_STOP   = 3'd7;

  // Write status codes
  localparam logic [1:0] WSTAT_OK    = 2'd0;
  localparam logic [1:0] WSTAT_NACK  = 2'd1;
  localparam logic [1:0] WSTAT_ABORT = 2'd2;

  localparam logic [6:0] SLAVE_ADDR_RESET = 7'd104;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_address;
    logic [15:0] write_data;
    logic        transmitter_idle;
    logic        ack_received;
    logic        rx_full;
    logic [7:0]  rx_byte;
    logic        stop_seen;
  } irts_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic        was_read;
    logic [15:0] read_data;
    logic [1:0]  write_status;
    logic        busy_res;
  } irts_result_t;

endpackage

[rtl/irts_seq.sv]
module irts_seq import irts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  irts_item_t   item_i,
  input  logic [6:0]   slave_address_i,
  output irts_result_t result_o
);

  logic [1:0]  mode_q, mode_d;
  logic [3:0]  step_q, step_d;
  logic        aborting_q, aborting_d;
  logic [7:0]  reg_byte_q, reg_byte_d;
  logic [15:0] data_word_q, data_word_d;
  logic        lbn_q, lbn_d;

  logic        busy;
  logic [3:0]  step_inc;
  logic [7:0]  wr_byte;
  logic        fin;
  logic        fin_ok;
  logic        abort;

  assign busy     = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
  assign step_inc = step_q + 4'd1;
  assign wr_byte  = {slave_address_i, 1'b0};

  // Work out the next sequence state and the bus action for one request
  always_comb begin
    mode_d      = mode_q;
    step_d      = step_q;
    aborting_d  = aborting_q;
    reg_byte_d  = reg_byte_q;
    data_word_d = data_word_q;
    lbn_d       = lbn_q;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    abort       = 1'b0;
    result_o    = '0;

    if ((item_i.func == FUNC_START_READ) || (item_i.func == FUNC_START_WRITE)) begin
      if (!busy && item_i.transmitter_idle) begin
        mode_d          = (item_i.func == FUNC_START_READ) ? MODE_READ : MODE_WRITE;
        step_d          = 4'd0;
        aborting_d      = 1'b0;
        reg_byte_d      = item_i.reg_address;
        data_word_d     = (item_i.func == FUNC_START_WRITE) ? item_i.write_data : 16'd0;
        lbn_d           = 1'b0;
        result_o.action = ACT_START;
      end
    end else if ((item_i.func == FUNC_BUS_EVENT) && busy) begin
      if (aborting_q) begin
        // Abort path: stop first, then finish with failure
        if (step_q == 4'd0) begin
          step_d          = 4'd1;
          result_o.action = ACT_STOP;
        end else begin
          fin = 1'b1;
        end
      end else begin
        step_d = step_inc;
        if (mode_q == MODE_READ) begin
          unique case (step_inc)
            4'd1: begin
              result_o.action  = ACT_TX;
              result_o.tx_byte = wr_byte;
            end
            4'd2: begin
              if (item_i.ack_received) begin
                result_o.action  = ACT_TX;
                result_o.tx_byte = reg_byte_q;
              end else abort = 1'b1;
            end
            4'd3: begin
              if (item_i.ack_received) result_o.action = ACT_RSTART;
              else abort = 1'b1;
            end
            4'd4: begin
              result_o.action  = ACT_TX;
              result_o.tx_byte = wr_byte | 8'd1;
            end
            4'd5: begin
              if (item_i.ack_received) result_o.action = ACT_RECV;
              else abort = 1'b1;
            end
            4'd6: begin
              if (item_i.rx_full) begin
                data_word_d[7:0] = item_i.rx_byte;
                result_o.action  = ACT_ACK;
              end else abort = 1'b1;
            end
            4'd7: begin
              if (item_i.ack_received) result_o.action = ACT_RECV;
              else abort = 1'b1;
            end
            4'd8: begin
              if (item_i.rx_full) begin
                data_word_d[15:8] = item_i.rx_byte;
                result_o.action   = ACT_NACK;
              end else abort = 1'b1;
            end
            4'd9:  result_o.action = ACT_STOP;
            4'd10: begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end else begin
          unique case (step_inc)
            4'd1: begin
              result_o.action  = ACT_TX;
              result_o.tx_byte = wr_byte;
            end
            4'd2: begin
              if (item_i.ack_received) begin
                result_o.action  = ACT_TX;
                result_o.tx_byte = reg_byte_q;
              end else abort = 1'b1;
            end
            4'd3: begin
              if (item_i.ack_received) begin
                result_o.action  = ACT_TX;
                result_o.tx_byte = data_word_q[7:0];
              end else abort = 1'b1;
            end
            4'd4: begin
              if (item_i.ack_received) begin
                result_o.action  = ACT_TX;
                result_o.tx_byte = data_word_q[15:8];
              end else abort = 1'b1;
            end
            4'd5: begin
              if (!item_i.ack_received) lbn_d = 1'b1;
              result_o.action = ACT_STOP;
            end
            4'd6: begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
    end

    // Enter the abort path: no action on this event
    if (abort) begin
      aborting_d = 1'b1;
      step_d     = 4'd0;
    end

    // Close the transaction and report its outcome
    if (fin) begin
      result_o.done_res = 1'b1;
      if (mode_q == MODE_READ) begin
        result_o.was_read  = 1'b1;
        result_o.read_data = (fin_ok && item_i.stop_seen) ? data_word_q : 16'd0;
      end else if (!fin_ok || !item_i.stop_seen) begin
        result_o.write_status = WSTAT_ABORT;
      end else begin
        result_o.write_status = lbn_q ? WSTAT_NACK : WSTAT_OK;
      end
      mode_d     = MODE_IDLE;
      step_d     = 4'd0;
      aborting_d = 1'b0;
    end

    result_o.busy_res = (mode_d == MODE_READ) || (mode_d == MODE_WRITE);
  end

  // Update sequence state once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      step_q      <= 4'd0;
      aborting_q  <= 1'b0;
      reg_byte_q  <= 8'd0;
      data_word_q <= 16'd0;
      lbn_q       <= 1'b0;
    end else if (advance_i) begin
      mode_q      <= mode_d;
      step_q      <= step_d;
      aborting_q  <= aborting_d;
      reg_byte_q  <= reg_byte_d;
      data_word_q <= data_word_d;
      lbn_q       <= lbn_d;
    end
  end

endmodule

[rtl/i2c_register_transfer_sequencer.sv]
// Register transfer sequencer for an I2C master talking to one slave.
// Slave side: one request per transfer (tuser = function code: start read,
// start write or bus event), tdata carries the register byte, write word and
// the bus engine status flags. Master side: one result per request, tuser =
// bus action to perform, tdata = byte to send plus transaction outcome.
// cfg_we_i/cfg_wdata_i load the 7-bit slave address; write it only while idle.
// A request accepted into the input register is evaluated against the sequence
// state, and its result is loaded into the output register once that register
// is free; tvalid then rises with the registered result.
// Throughput: one request per cycle while the result stream is not stalled;
// the sequence state is updated together with the output register.
// Reset clears the sequence to idle, the slave address to 104 and both valid
// flags. When the receiver stalls, the output register holds its result and
// the input register holds one more request; s_axis_tready drops after that.
module i2c_register_transfer_sequencer import irts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: slave address
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_wdata_i,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] reg_address, [23:8] write_data, [24] transmitter_idle,
  // [25] ack_received, [26] rx_full, [34:27] rx_byte, [35] stop_seen
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]            s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] tx_byte, [8] done_res, [9] was_read, [25:10] read_data,
  // [27:26] write_status, [28] busy_res
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] action
  output logic [2:0]            m_axis_tuser
);

  logic         in_valid_q;
  irts_item_t   in_item_q, in_item_d;
  logic         out_valid_q;
  irts_result_t out_q, result;
  logic [6:0]   slave_addr_q;
  logic         out_free;
  logic         advance;

  // Slave address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RESET;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Unpack the request
  always_comb begin
    in_item_d.func             = s_axis_tuser;
    in_item_d.reg_address      = s_axis_tdata[7:0];
    in_item_d.write_data       = s_axis_tdata[23:8];
    in_item_d.transmitter_idle = s_axis_tdata[24];
    in_item_d.ack_received     = s_axis_tdata[25];
    in_item_d.rx_full          = s_axis_tdata[26];
    in_item_d.rx_byte          = s_axis_tdata[34:27];
    in_item_d.stop_seen        = s_axis_tdata[35];
  end

  // Input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
    end
  end

  irts_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .item_i          (in_item_q),
    .slave_address_i (slave_addr_q),
    .result_o        (result)
  );

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // Pack the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {3'b000, out_q.busy_res, out_q.write_status, out_q.read_data,
                          out_q.was_read, out_q.done_res, out_q.tx_byte};

endmodule
